@@ rtl/hsvrgb_pkg.sv @@
// Shared types and constants for the HSV to RGB color converter.
package hsvrgb_pkg;

  localparam int HUE_W   = 9;   // hue in degrees
  localparam int PCT_W   = 7;   // saturation and value in percent
  localparam int LVL_W   = 8;   // output channel level
  localparam int WGT_W   = 6;   // secondary weight, 0..60
  localparam int PROD_W  = 14;  // value times saturation, 0..10000
  localparam int NUM_W   = 20;  // channel numerator over 600000
  localparam int Y_W     = 24;  // scaled and biased numerator
  localparam int Z_W     = 18;  // numerator with the 64 factor removed
  localparam int Z_SHIFT = Y_W - Z_W;
  localparam int RCP_W   = 15;  // reciprocal of 625
  localparam int RCP_SHIFT = 24;
  localparam int QE_W    = 9;   // quotient estimate

  typedef logic [HUE_W-1:0]  hue_t;
  typedef logic [PCT_W-1:0]  pct_t;
  typedef logic [LVL_W-1:0]  level_t;
  typedef logic [WGT_W-1:0]  wgt_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [NUM_W-1:0]  num_t;

  localparam hue_t   HUE_WRAP   = 9'd360;
  localparam hue_t   HUE_120    = 9'd120;
  localparam hue_t   HUE_180    = 9'd180;
  localparam hue_t   HUE_240    = 9'd240;
  localparam hue_t   HUE_300    = 9'd300;
  localparam hue_t   SECTOR_DEG = 9'd60;
  localparam pct_t   PCT_MAX    = 7'd100;
  localparam num_t   VAL_SCALE  = 20'd6000;
  localparam num_t   SECTOR_NUM = 20'd60;

  // Rounding: (255*n + 300000) / 600000 == (17*n + 20000) / 40000,
  // and 40000 = 64 * 625. The divide by 625 uses a floor reciprocal
  // of 2^24/625 followed by a single upward correction.
  localparam logic [Y_W-1:0]   ROUND_BIAS = 24'd20000;
  localparam logic [RCP_W-1:0] RECIP      = 15'd26843;
  localparam logic [Z_W-1:0]   DIV_LO     = 18'd625;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

@@ rtl/hsvrgb_round.sv @@
// Two-stage rounding of one channel numerator over 600000 to an 8-bit level.
module hsvrgb_round (
  input  logic              clk,
  input  logic              en,
  input  hsvrgb_pkg::num_t  num,
  output hsvrgb_pkg::level_t level
);
  import hsvrgb_pkg::*;

  logic [Y_W-1:0]         y;
  logic [Z_W-1:0]         z_r;
  logic [Z_W-1:0]         z2_r;
  logic [Z_W+RCP_W-1:0]   prod;
  logic [QE_W-1:0]        qe_r;
  logic [Z_W-1:0]         back;
  logic [Z_W-1:0]         rem;

  // 17*n + 20000, then drop the factor of 64 from the divisor.
  assign y = (Y_W'(num) << 4) + Y_W'(num) + ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (en) begin
      z_r <= y[Y_W-1:Z_SHIFT];
    end
  end

  assign prod = (Z_W+RCP_W)'(z_r) * (Z_W+RCP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      qe_r <= prod[RCP_SHIFT +: QE_W];
      z2_r <= z_r;
    end
  end

  // The estimate is the true quotient or one below it.
  assign back  = Z_W'(qe_r) * DIV_LO;
  assign rem   = z2_r - back;
  assign level = (rem >= DIV_LO) ? LVL_W'(qe_r + 1'b1) : LVL_W'(qe_r);

endmodule

@@ rtl/hsv_to_rgb_converter_unit.sv @@
// Top level of the pipelined HSV to RGB color converter.
// Throughput: one word per clock cycle, sustained while out_tready stays high.
// An accepted input word passes through the five register stages and then the
// output register before it is presented as a result word.
// Reset (rst_n low, synchronous) empties the pipeline, the output register and
// the skid register; the datapath registers themselves are not reset.
module hsv_to_rgb_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [8:0] hue_degrees, [15:9] saturation_pct,
                                  // [22:16] value_pct, [23] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [7:0] red_level, [15:8] green_level,
                                  // [23:16] blue_level
);
  import hsvrgb_pkg::*;

  // The whole pipeline advances together whenever the skid register is
  // empty. The skid register catches the one word that leaves the last
  // stage in the cycle the output register turns out to be blocked, so
  // in_tready is a register output and never depends on out_tready.
  logic en;

  // Stage 1: wrap and clamp the inputs, find the sector and the weight of
  // the secondary component, and form value times saturation.
  hue_t    hue_in;
  pct_t    sat_in;
  pct_t    val_in;
  hue_t    hue;
  pct_t    sat;
  pct_t    val;
  hue_t    rem120;
  hue_t    mid_dist;
  sector_t sector;
  logic    v1_r;
  sector_t sector1_r;
  wgt_t    wgt1_r;
  prod_t   vs1_r;
  pct_t    val1_r;

  assign hue_in = in_tdata[8:0];
  assign sat_in = in_tdata[15:9];
  assign val_in = in_tdata[22:16];

  always_comb begin
    hue = (hue_in >= HUE_WRAP) ? hue_in - HUE_WRAP : hue_in;
    sat = (sat_in > PCT_MAX) ? PCT_MAX : sat_in;
    val = (val_in > PCT_MAX) ? PCT_MAX : val_in;

    if (hue >= HUE_300) begin
      sector = SEC_MAG_RED;
    end else if (hue >= HUE_240) begin
      sector = SEC_BLU_MAG;
    end else if (hue >= HUE_180) begin
      sector = SEC_CYN_BLU;
    end else if (hue >= HUE_120) begin
      sector = SEC_GRN_CYN;
    end else if (hue >= SECTOR_DEG) begin
      sector = SEC_YEL_GRN;
    end else begin
      sector = SEC_RED_YEL;
    end

    if (hue >= HUE_240) begin
      rem120 = hue - HUE_240;
    end else if (hue >= HUE_120) begin
      rem120 = hue - HUE_120;
    end else begin
      rem120 = hue;
    end

    // Distance from the middle of the 120-degree pair of sectors.
    mid_dist = (rem120 >= SECTOR_DEG) ? rem120 - SECTOR_DEG : SECTOR_DEG - rem120;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sector1_r <= sector;
      wgt1_r    <= WGT_W'(SECTOR_DEG - mid_dist);
      vs1_r     <= PROD_W'(sat) * PROD_W'(val);
      val1_r    <= val;
    end
  end

  // Stage 2: chroma, secondary component and offset, all over 600000.
  num_t    x_nxt;
  num_t    c_nxt;
  num_t    m_nxt;
  logic    v2_r;
  sector_t sector2_r;
  num_t    x2_r;
  num_t    c2_r;
  num_t    m2_r;

  assign x_nxt = NUM_W'(vs1_r) * NUM_W'(wgt1_r);
  assign c_nxt = NUM_W'(vs1_r) * SECTOR_NUM;
  assign m_nxt = NUM_W'(val1_r) * VAL_SCALE - c_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      sector2_r <= sector1_r;
      x2_r      <= x_nxt;
      c2_r      <= c_nxt;
      m2_r      <= m_nxt;
    end
  end

  // Stage 3: route chroma and the secondary component by sector and add
  // the offset to every channel. Index 0 is red, 1 green, 2 blue.
  num_t sel [3];
  num_t n3_r [3];
  logic v3_r;

  always_comb begin
    case (sector2_r)
      SEC_RED_YEL: begin sel[0] = c2_r;  sel[1] = x2_r;  sel[2] = '0;    end
      SEC_YEL_GRN: begin sel[0] = x2_r;  sel[1] = c2_r;  sel[2] = '0;    end
      SEC_GRN_CYN: begin sel[0] = '0;    sel[1] = c2_r;  sel[2] = x2_r;  end
      SEC_CYN_BLU: begin sel[0] = '0;    sel[1] = x2_r;  sel[2] = c2_r;  end
      SEC_BLU_MAG: begin sel[0] = x2_r;  sel[1] = '0;    sel[2] = c2_r;  end
      default:     begin sel[0] = c2_r;  sel[1] = '0;    sel[2] = x2_r;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n3_r[i] <= sel[i] + m2_r;
      end
    end
  end

  // Stages 4 and 5: rounding to 8-bit levels, one unit per channel.
  level_t lvl [3];
  logic   v4_r;
  logic   v5_r;

  for (genvar g = 0; g < 3; g++) begin : g_round
    hsvrgb_round u_round (
      .clk   (clk),
      .en    (en),
      .num   (n3_r[g]),
      .level (lvl[g])
    );
  end

  // Output register and skid register.
  logic [23:0] result;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [23:0] out_data_r;
  logic [23:0] out_data_nxt;
  logic        skid_valid_r;
  logic        skid_valid_nxt;
  logic [23:0] skid_data_r;
  logic [23:0] skid_data_nxt;

  assign result = {lvl[2], lvl[1], lvl[0]};
  assign en     = ~skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      // Pipeline is frozen; drain the skid word once the output moves.
      if (out_tready) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (v5_r) begin
      if (!out_valid_r || out_tready) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = result;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = result;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      v5_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (en) begin
        v1_r <= in_tvalid;
        v2_r <= v1_r;
        v3_r <= v2_r;
        v4_r <= v3_r;
        v5_r <= v4_r;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // A word sits in the skid register only behind a word in the output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a word while the output register is empty");

  // A blocked skid word is not dropped.
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_tready |=> skid_valid_r && $stable(skid_data_r))
    else $error("skid word lost or changed while the output was stalled");

  // A word in the last pipeline stage stays put while the pipeline is frozen.
  a_stage5_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && !en |=> v5_r)
    else $error("last pipeline stage lost its word during a stall");
`endif

endmodule

@@ verif/tb_hsv_to_rgb_converter_unit.sv @@
// Testbench for the HSV to RGB converter: random and directed colors, checked per channel.
module tb_hsv_to_rgb_converter_unit;
  import hsvrgb_pkg::*;

  // Result levels of one color, red first as on out_tdata.
  typedef struct {
    level_t red;
    level_t green;
    level_t blue;
  } rgb_levels_t;

  // Holds the colors expected from the converter in arrival order and checks each
  // result word against the oldest one.
  class rgb_scoreboard;
    rgb_levels_t expected_q[$];
    int          error_count;

    function new();
      error_count = 0;
    endfunction

    // Integer model of the conversion. Every channel is a numerator over 600000,
    // so the only rounding is the final scaling to 0..255.
    function rgb_levels_t convert_hsv(hue_t hue_in, pct_t sat_in, pct_t val_in);
      int unsigned hue, sat, val, hue_mod, mid_dist, chroma, second, offset;
      int unsigned num [3];
      sector_t     sector;
      rgb_levels_t rgb;
      hue      = int'(hue_in) % 360;
      sat      = (sat_in > 7'd100) ? 100 : int'(sat_in);
      val      = (val_in > 7'd100) ? 100 : int'(val_in);
      hue_mod  = hue % 120;
      mid_dist = (hue_mod >= 60) ? hue_mod - 60 : 60 - hue_mod;
      chroma   = val * sat * 60;
      second   = val * sat * (60 - mid_dist);
      offset   = val * 6000 - chroma;
      sector   = sector_t'(hue / 60);
      case (sector)
        SEC_RED_YEL: begin num[0] = chroma; num[1] = second; num[2] = 0;      end
        SEC_YEL_GRN: begin num[0] = second; num[1] = chroma; num[2] = 0;      end
        SEC_GRN_CYN: begin num[0] = 0;      num[1] = chroma; num[2] = second; end
        SEC_CYN_BLU: begin num[0] = 0;      num[1] = second; num[2] = chroma; end
        SEC_BLU_MAG: begin num[0] = second; num[1] = 0;      num[2] = chroma; end
        default:     begin num[0] = chroma; num[1] = 0;      num[2] = second; end
      endcase
      for (int k = 0; k < 3; k++) begin
        num[k] = (255 * (num[k] + offset) + 300000) / 600000;
      end
      rgb.red   = level_t'(num[0]);
      rgb.green = level_t'(num[1]);
      rgb.blue  = level_t'(num[2]);
      return rgb;
    endfunction

    function void note_input(logic [23:0] word);
      expected_q.push_back(convert_hsv(word[8:0], word[15:9], word[22:16]));
    endfunction

    function void check_result(logic [23:0] word);
      rgb_levels_t want;
      rgb_levels_t got;
      got.red   = word[7:0];
      got.green = word[15:8];
      got.blue  = word[23:16];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word r=%0d g=%0d b=%0d", $time,
                 got.red, got.green, got.blue);
        error_count++;
        return;
      end
      want = expected_q.pop_front();
      if (got.red !== want.red) begin
        $display("%0t: red mismatch, expected %0d, actual %0d", $time, want.red, got.red);
        error_count++;
      end
      if (got.green !== want.green) begin
        $display("%0t: green mismatch, expected %0d, actual %0d", $time, want.green,
                 got.green);
        error_count++;
      end
      if (got.blue !== want.blue) begin
        $display("%0t: blue mismatch, expected %0d, actual %0d", $time, want.blue,
                 got.blue);
        error_count++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // The backlog stall has to outlast the five-stage pipeline by a wide margin so
  // that the converter really fills up and drops in_tready.
  localparam int BACKLOG_STALL = 64;
  // Cycles in which no word moves on either channel before the run is declared
  // hung. The longest correct silence is the backlog stall plus the latency.
  localparam int HANG_LIMIT    = 2000;
  localparam int PHASE_ITEMS   = 225;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  rgb_scoreboard sb;
  int            send_idle_pct;
  int            recv_idle_pct;
  bit            start_backlog;
  int            quiet_cycles;

  hsv_to_rgb_converter_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The word layout matches the port comment: hue in the low bits, then
  // saturation, then value, with the top bit held at zero.
  function automatic logic [23:0] hsv_word(int hue, int sat, int val);
    return {1'b0, pct_t'(val), pct_t'(sat), hue_t'(hue)};
  endfunction

  // Most colors stay inside the documented ranges. The rest use the full field
  // widths so that hue wrapping and percent clamping get exercised and every bit
  // of every field toggles.
  function automatic logic [23:0] random_color();
    if ($urandom_range(0, 99) < 75) begin
      return hsv_word($urandom_range(0, 359), $urandom_range(0, 100),
                      $urandom_range(0, 100));
    end
    return hsv_word($urandom_range(0, 511), $urandom_range(0, 127),
                    $urandom_range(0, 127));
  endfunction

  // Offers one word, possibly after some idle cycles, and returns at the falling
  // edge after the word was taken. in_tvalid is left high so that back-to-back
  // words go out without a gap; every call touches it only once per falling edge.
  task automatic send_color(logic [23:0] word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_random_colors(int count);
    for (int k = 0; k < count; k++) begin
      send_color(random_color());
    end
  endtask

  // Stops offering words and waits at the falling edge until every expected
  // result word has come back. The watchdog guards against a hang here.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Receiver. It drives out_tready at the falling edge, either at random or held
  // low for a long backlog stall that it counts by itself.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (start_backlog) begin
        start_backlog = 1'b0;
        stall_left    = BACKLOG_STALL - 1;
        out_tready   <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Monitor. Both channels are sampled at the rising edge, before the converter
  // updates its outputs, so a word counts exactly when its handshake completes.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // Watchdog. It counts cycles in which neither channel moves a word.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, HANG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    start_backlog = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 72;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed colors: every sector boundary at full saturation and value, then
    // the hue wrap, clamped percentages, gray and black.
    for (int k = 0; k < 6; k++) begin
      send_color(hsv_word(60 * k, 100, 100));
      send_color(hsv_word(60 * k + 59, 100, 100));
    end
    send_color(hsv_word(360, 100, 100));
    send_color(hsv_word(511, 100, 100));
    send_color(hsv_word(90, 127, 60));
    send_color(hsv_word(200, 40, 127));
    send_color(hsv_word(270, 101, 101));
    send_color(hsv_word(45, 0, 75));
    send_color(hsv_word(150, 90, 0));
    send_color(hsv_word(0, 0, 0));
    send_color(hsv_word(511, 127, 127));
    send_color(hsv_word(30, 50, 50));

    // First phase: the sender idles now and then, the receiver most of the time.
    send_random_colors(PHASE_ITEMS);

    // Backlog: the receiver holds off for a long stretch while the sender keeps
    // offering words, so the pipeline fills and in_tready has to drop.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    start_backlog = 1'b1;
    send_random_colors(40);

    // The sender pauses until the converter has handed back everything.
    wait_for_drain();

    // Second phase with the idle rates swapped, third phase with no idling.
    send_idle_pct = 72;
    recv_idle_pct = 34;
    send_random_colors(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_colors(PHASE_ITEMS);

    // Let the last words come out, then give the pipeline a few more cycles in
    // case it produces a word nobody asked for.
    wait_for_drain();
    repeat (12) @(negedge clk);
    if (sb.error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/hsvrgb_pkg.sv
rtl/hsvrgb_round.sv
rtl/hsv_to_rgb_converter_unit.sv
verif/tb_hsv_to_rgb_converter_unit.sv
